[hdl/bfca_pkg.sv]
// Package for the best-fit coalescing allocator: constants, codes and FSM type.
// No dependencies.
`timescale 1ns / 1ps
package bfca_pkg;
    localparam int MAX_FREE_BLOCKS_DEF = 64;
    localparam int ALIGN_BYTES_DEF     = 8;
    localparam int CFG_W               = 21;
    localparam int PAGE_BYTES_RST      = 4096;
    localparam int SPLIT_SLACK_RST     = 1024;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_OOM  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic REG_PAGE_BYTES  = 1'b0;
    localparam logic REG_SPLIT_SLACK = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_WRITE,
        S_WRITE2,
        S_RESP
    } state_t;
endpackage

[hdl/bfca_if.sv]
// Valid/ready channel interfaces for the allocator.
// Field widths are written as literals; no package dependency.
`timescale 1ns / 1ps
interface bfca_req_if;
    logic        valid;
    logic        ready;
    logic        action;
    logic [31:0] req_size;
    logic [31:0] req_offset;
    modport source (output valid, action, req_size, req_offset, input ready);
    modport sink   (input valid, action, req_size, req_offset, output ready);
endinterface

interface bfca_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] granted_offset;
    logic [31:0] granted_size;
    modport source (output valid, status, granted_offset, granted_size, input ready);
    modport sink   (input valid, status, granted_offset, granted_size, output ready);
endinterface

interface bfca_cfg_if;
    logic        valid;
    logic        ready;
    logic        index;
    logic [20:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[hdl/best_fit_coalescing_allocator.sv]
// Top level of the best-fit coalescing allocator: free table in two RAMs,
// scanned one entry per cycle. Depends on bfca_pkg and bfca_if.
`timescale 1ns / 1ps
// channel | dir | payload
// req     | in  | action, req_size, req_offset
// rsp     | out | status, granted_offset, granted_size
// cfg     | in  | index (0 page bytes, 1 split slack), data
// An item goes from accept to response through these steps: the accept in
// S_IDLE, the scan (one RAM read per entry plus read latency), a decide
// state, S_WRITE when a write is due, S_WRITE2 after a two-sided merge, the response.
// Valid bits are flip-flops cleared by rst_n; the RAMs need no clear.
// A stalled response holds the block; cfg is always ready.
module best_fit_coalescing_allocator
    import bfca_pkg::*;
#(
    parameter int MAX_FREE_BLOCKS = MAX_FREE_BLOCKS_DEF,
    parameter int ALIGN_BYTES     = ALIGN_BYTES_DEF
) (
    input logic clk,
    input logic rst_n,
    bfca_req_if.sink   req,
    bfca_rsp_if.source rsp,
    bfca_cfg_if.sink   cfg
);
    localparam int IW = (MAX_FREE_BLOCKS > 1) ? $clog2(MAX_FREE_BLOCKS) : 1;
    localparam int CW = IW + 1;
    localparam logic [63:0] ALIGN64 = 64'(ALIGN_BYTES);

    logic [31:0] start_mem [MAX_FREE_BLOCKS];
    logic [31:0] len_mem   [MAX_FREE_BLOCKS];
    logic [MAX_FREE_BLOCKS-1:0] valid_reg, valid_next;

    state_t state_reg, state_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          rd_pend_reg, rd_pend_next;
    logic [IW-1:0] rd_idx_reg, rd_idx_next;
    logic [31:0]   rd_start_reg, rd_len_reg;

    logic [CFG_W-1:0] page_reg, slack_reg;

    logic          act_reg, act_next;
    logic [63:0]   asz_reg, asz_next;
    logic [31:0]   size_reg, size_next, off_reg, off_next;

    logic          b_ok_reg, b_ok_next;
    logic [IW-1:0] b_idx_reg, b_idx_next;
    logic [31:0]   b_start_reg, b_start_next, b_len_reg, b_len_next;
    logic          p_ok_reg, p_ok_next, s_ok_reg, s_ok_next, dup_reg, dup_next;
    logic [IW-1:0] p_idx_reg, p_idx_next, s_idx_reg, s_idx_next;
    logic [31:0]   p_start_reg, p_start_next, p_len_reg, p_len_next;
    logic [31:0]   s_start_reg, s_start_next, s_len_reg, s_len_next;
    logic          e_ok_reg, e_ok_next;
    logic [IW-1:0] e_idx_reg, e_idx_next;

    logic          we_reg, we_next;
    logic [IW-1:0] wa_reg, wa_next;
    logic [31:0]   wst_reg, wst_next, wln_reg, wln_next;
    logic          inv2_reg, inv2_next;
    logic [IW-1:0] inv2_idx_reg, inv2_idx_next;

    logic [1:0]  st_reg, st_next;
    logic [31:0] go_reg, go_next, gs_reg, gs_next;

    logic [63:0] aligned_c, rest_c;
    logic [32:0] p_end_c, s_tot_c, p_tot_c;

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;
    assign rsp.valid = (state_reg == S_RESP);
    assign rsp.status = st_reg;
    assign rsp.granted_offset = go_reg;
    assign rsp.granted_size = gs_reg;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            page_reg  <= CFG_W'(PAGE_BYTES_RST);
            slack_reg <= CFG_W'(SPLIT_SLACK_RST);
        end else if (cfg.valid) begin
            if (cfg.index == REG_PAGE_BYTES) page_reg <= cfg.data;
            else slack_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk) begin
        if (we_reg) begin
            start_mem[wa_reg] <= wst_reg;
            len_mem[wa_reg]   <= wln_reg;
        end
        rd_start_reg <= start_mem[cnt_reg[IW-1:0]];
        rd_len_reg   <= len_mem[cnt_reg[IW-1:0]];
    end

    always_comb begin
        rest_c = 64'({32'd0, req.req_size} % ALIGN64);
        aligned_c = {32'd0, req.req_size};
        if (rest_c != 64'd0) aligned_c = aligned_c + (ALIGN64 - rest_c);
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:   if (req.valid) state_next = S_SCAN;
            S_SCAN:   if (!(cnt_reg < CW'(MAX_FREE_BLOCKS)) && !rd_pend_reg)
                          state_next = S_DECIDE;
            S_DECIDE: state_next = we_next ? S_WRITE : S_RESP;
            S_WRITE:  state_next = inv2_reg ? S_WRITE2 : S_RESP;
            S_WRITE2: state_next = S_RESP;
            S_RESP:   if (rsp.ready) state_next = S_IDLE;
            default:  state_next = S_IDLE;
        endcase
    end

    assign p_end_c = {1'b0, p_start_reg} + {1'b0, p_len_reg};
    assign p_tot_c = {1'b0, size_reg} + {1'b0, p_len_reg};

    always_comb begin
        logic [32:0] tot;
        logic [31:0] base;
        logic        pm, sm;
        logic [32:0] se;
        valid_next = valid_reg;
        cnt_next = cnt_reg; rd_pend_next = rd_pend_reg; rd_idx_next = rd_idx_reg;
        act_next = act_reg; asz_next = asz_reg; size_next = size_reg; off_next = off_reg;
        b_ok_next = b_ok_reg; b_idx_next = b_idx_reg;
        b_start_next = b_start_reg; b_len_next = b_len_reg;
        p_ok_next = p_ok_reg; p_idx_next = p_idx_reg;
        p_start_next = p_start_reg; p_len_next = p_len_reg;
        s_ok_next = s_ok_reg; s_idx_next = s_idx_reg;
        s_start_next = s_start_reg; s_len_next = s_len_reg;
        dup_next = dup_reg; e_ok_next = e_ok_reg; e_idx_next = e_idx_reg;
        we_next = 1'b0; wa_next = wa_reg; wst_next = wst_reg; wln_next = wln_reg;
        inv2_next = inv2_reg; inv2_idx_next = inv2_idx_reg;
        st_next = st_reg; go_next = go_reg; gs_next = gs_reg;
        tot = '0; base = '0; pm = 1'b0; sm = 1'b0; se = '0;
        s_tot_c = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (req.valid) begin
                    act_next = req.action; asz_next = aligned_c;
                    size_next = req.req_size; off_next = req.req_offset;
                    cnt_next = '0; rd_pend_next = 1'b0;
                    b_ok_next = 1'b0; p_ok_next = 1'b0; s_ok_next = 1'b0;
                    dup_next = 1'b0; e_ok_next = 1'b0; inv2_next = 1'b0;
                end
            end
            S_SCAN: begin
                if (rd_pend_reg && valid_reg[rd_idx_reg]) begin
                    if (act_reg == ACT_ALLOC) begin
                        if ({32'd0, rd_len_reg} > asz_reg &&
                            (!b_ok_reg || rd_len_reg < b_len_reg ||
                             (rd_len_reg == b_len_reg && rd_start_reg < b_start_reg))) begin
                            b_ok_next = 1'b1; b_idx_next = rd_idx_reg;
                            b_start_next = rd_start_reg; b_len_next = rd_len_reg;
                        end
                    end else begin
                        if (rd_start_reg == off_reg) dup_next = 1'b1;
                        else if (rd_start_reg < off_reg) begin
                            if (!p_ok_reg || rd_start_reg > p_start_reg) begin
                                p_ok_next = 1'b1; p_idx_next = rd_idx_reg;
                                p_start_next = rd_start_reg; p_len_next = rd_len_reg;
                            end
                        end else if (!s_ok_reg || rd_start_reg < s_start_reg) begin
                            s_ok_next = 1'b1; s_idx_next = rd_idx_reg;
                            s_start_next = rd_start_reg; s_len_next = rd_len_reg;
                        end
                    end
                end else if (rd_pend_reg && !e_ok_reg) begin
                    e_ok_next = 1'b1; e_idx_next = rd_idx_reg;
                end
                rd_pend_next = (cnt_reg < CW'(MAX_FREE_BLOCKS));
                rd_idx_next = cnt_reg[IW-1:0];
                if (cnt_reg < CW'(MAX_FREE_BLOCKS)) cnt_next = cnt_reg + CW'(1);
            end
            S_DECIDE: begin
                st_next = ST_OK; go_next = '0; gs_next = '0;
                if (act_reg == ACT_ALLOC) begin
                    if (!b_ok_reg) st_next = ST_OOM;
                    else begin
                        go_next = b_start_reg;
                        if ({32'd0, b_len_reg} > {asz_reg[62:0], 1'b0} ||
                            (b_len_reg > 32'(page_reg) &&
                             ({32'd0, b_len_reg} - asz_reg) > 64'(slack_reg))) begin
                            we_next = 1'b1; wa_next = b_idx_reg;
                            wst_next = b_start_reg + asz_reg[31:0];
                            wln_next = b_len_reg - asz_reg[31:0];
                            gs_next = asz_reg[31:0];
                        end else begin
                            valid_next[b_idx_reg] = 1'b0;
                            gs_next = b_len_reg;
                        end
                    end
                end else if (!dup_reg) begin
                    pm = p_ok_reg && p_end_c == {1'b0, off_reg} && !p_tot_c[32];
                    tot = pm ? p_tot_c : {1'b0, size_reg};
                    base = pm ? p_start_reg : off_reg;
                    se = {1'b0, off_reg} + {1'b0, size_reg};
                    s_tot_c = tot + {1'b0, s_len_reg};
                    sm = s_ok_reg && se == {1'b0, s_start_reg} && !s_tot_c[32];
                    if (sm) tot = s_tot_c;
                    if (pm) begin
                        we_next = 1'b1; wa_next = p_idx_reg;
                        if (sm) begin inv2_next = 1'b1; inv2_idx_next = s_idx_reg; end
                    end else if (sm) begin
                        we_next = 1'b1; wa_next = s_idx_reg;
                    end else if (e_ok_reg) begin
                        we_next = 1'b1; wa_next = e_idx_reg;
                    end else st_next = ST_FULL;
                    wst_next = base; wln_next = tot[31:0];
                end
            end
            S_WRITE: begin
                valid_next[wa_reg] = 1'b1;
                if (inv2_reg) valid_next[inv2_idx_reg] = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= S_IDLE; valid_reg <= '0; we_reg <= 1'b0;
            cnt_reg <= '0; rd_pend_reg <= 1'b0;
        end else begin
            state_reg <= state_next; valid_reg <= valid_next; we_reg <= we_next;
            cnt_reg <= cnt_next; rd_pend_reg <= rd_pend_next;
        end
    end

    always_ff @(posedge clk) begin
        rd_idx_reg <= rd_idx_next;
        act_reg <= act_next; asz_reg <= asz_next; size_reg <= size_next; off_reg <= off_next;
        b_ok_reg <= b_ok_next; b_idx_reg <= b_idx_next;
        b_start_reg <= b_start_next; b_len_reg <= b_len_next;
        p_ok_reg <= p_ok_next; p_idx_reg <= p_idx_next;
        p_start_reg <= p_start_next; p_len_reg <= p_len_next;
        s_ok_reg <= s_ok_next; s_idx_reg <= s_idx_next;
        s_start_reg <= s_start_next; s_len_reg <= s_len_next;
        dup_reg <= dup_next; e_ok_reg <= e_ok_next; e_idx_reg <= e_idx_next;
        wa_reg <= wa_next; wst_reg <= wst_next; wln_reg <= wln_next;
        inv2_reg <= inv2_next; inv2_idx_reg <= inv2_idx_next;
        st_reg <= st_next; go_reg <= go_next; gs_reg <= gs_next;
    end

    a_write_only_in_write: assert property (@(posedge clk) disable iff (!rst_n)
        we_reg |-> state_reg == S_WRITE) else $error("RAM write outside write state");
    a_ok_alloc_nonzero_or_free: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.granted_size == 32'd0 &&
        rsp.granted_offset == 32'd0)) else $error("error response carries a grant");
    a_no_req_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !req.ready) else $error("ready during scan");
    a_merge_frees_one: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_WRITE && inv2_reg) |=> !valid_reg[$past(inv2_idx_reg)])
        else $error("merged successor still valid");
endmodule
